// ===== rtl/core/tlbpc_pkg.sv =====
// ----------------------------------------------------------------------------
// tlbpc_pkg
// Shared types and constants for the TLB with per-process counters.
// ----------------------------------------------------------------------------
package tlbpc_pkg;

  localparam int ENTRIES_DEF    = 16;
  localparam int PROCESSES_DEF  = 256;
  localparam int PAGE_BITS_DEF  = 20;
  localparam int FRAME_BITS_DEF = 16;

  localparam int PID_W   = 8;
  localparam int CNT_W   = 32;
  localparam int STAMP_W = 32;
  localparam int OUT_PAGE_W  = 20;
  localparam int OUT_FRAME_W = 16;

  typedef enum logic [1:0] {
    KIND_LOOKUP = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_FLUSH  = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [0:0] {
    REG_POLICY = 1'b0,
    REG_ACTIVE = 1'b1
  } reg_idx_t;

  localparam logic POLICY_LRU  = 1'b0;
  localparam logic POLICY_FIFO = 1'b1;

endpackage

// ===== rtl/core/tlbpc_front.sv =====
// ----------------------------------------------------------------------------
// tlbpc_front
// Input stage: takes items and queues them for the back end.
// Two-entry queue decouples input from the execution engine.
// ----------------------------------------------------------------------------
module tlbpc_front #(
  parameter int PAGE_BITS  = tlbpc_pkg::PAGE_BITS_DEF,
  parameter int FRAME_BITS = tlbpc_pkg::FRAME_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  logic [1:0]                  kind,
  input  logic [tlbpc_pkg::PID_W-1:0] process_id,
  input  logic [PAGE_BITS-1:0]        page_number,
  input  logic [FRAME_BITS-1:0]       frame_number,
  output logic                        q_valid,
  input  logic                        q_take,
  output logic [1:0]                  q_kind,
  output logic [tlbpc_pkg::PID_W-1:0] q_pid,
  output logic [PAGE_BITS-1:0]        q_page,
  output logic [FRAME_BITS-1:0]       q_frame
);
  import tlbpc_pkg::*;

  localparam int QW = 2 + PID_W + PAGE_BITS + FRAME_BITS;

  logic [QW-1:0] mem [2];
  logic          wp, rp;
  logic [1:0]    cnt;
  logic          do_push, do_pop;

  assign full    = (cnt == 2'd2);
  assign q_valid = (cnt != 2'd0);
  assign do_push = push && !full;
  assign do_pop  = q_take && q_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wp] <= {kind, process_id, page_number, frame_number};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (do_push) wp <= !wp;
      if (do_pop)  rp <= !rp;
      cnt <= cnt + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  assign {q_kind, q_pid, q_page, q_frame} = mem[rp];

endmodule

// ===== rtl/core/tlbpc_back.sv =====
// ----------------------------------------------------------------------------
// tlbpc_back
// Execution engine: entry array, victim choice, per-process counters and
// result register. Counter stores are cleared by a sweep after reset.
// ----------------------------------------------------------------------------
module tlbpc_back #(
  parameter int ENTRIES    = tlbpc_pkg::ENTRIES_DEF,
  parameter int PROCESSES  = tlbpc_pkg::PROCESSES_DEF,
  parameter int PAGE_BITS  = tlbpc_pkg::PAGE_BITS_DEF,
  parameter int FRAME_BITS = tlbpc_pkg::FRAME_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        policy,
  input  logic [4:0]                  active_cfg,
  input  logic                        q_valid,
  output logic                        q_take,
  input  logic [1:0]                  q_kind,
  input  logic [tlbpc_pkg::PID_W-1:0] q_pid,
  input  logic [PAGE_BITS-1:0]        q_page,
  input  logic [FRAME_BITS-1:0]       q_frame,
  output logic                        empty,
  input  logic                        pop,
  output logic                        hit,
  output logic [15:0]                 found_frame,
  output logic [31:0]                 event_count,
  output logic                        victim_valid,
  output logic [7:0]                  victim_process,
  output logic [19:0]                 victim_page
);
  import tlbpc_pkg::*;

  localparam int EW = $clog2(ENTRIES);
  localparam int NW = $clog2(ENTRIES + 1);
  localparam int SW = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;
  localparam int TP = 1 << EW;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_EXEC  = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t state;

  logic                  ev   [ENTRIES];
  logic [PID_W-1:0]      epid [ENTRIES];
  logic [PAGE_BITS-1:0]  epg  [ENTRIES];
  logic [FRAME_BITS-1:0] efr  [ENTRIES];
  logic [STAMP_W-1:0]    est  [ENTRIES];
  logic [STAMP_W-1:0]    use_clock;
  logic [EW-1:0]         fifo_head;

  logic [CNT_W-1:0] hmem [PROCESSES];
  logic [CNT_W-1:0] mmem [PROCESSES];
  logic [CNT_W-1:0] hrd, mrd;
  logic [SW-1:0]    clr_idx;

  // latched item
  logic [1:0]            k;
  logic [PID_W-1:0]      pid;
  logic [PAGE_BITS-1:0]  pg;
  logic [FRAME_BITS-1:0] fr;
  logic [SW-1:0]         slot;

  // stage-1 registered search results
  logic          m_hit;
  logic [EW-1:0] m_idx;
  logic [EW-1:0] v_idx;

  // output register
  logic out_full;
  logic fire;

  // active count
  logic [NW-1:0] n;
  always_comb begin
    if (active_cfg == 5'd0) n = NW'(1);
    else if ({27'd0, active_cfg} > 32'(ENTRIES)) n = NW'(ENTRIES);
    else n = NW'(active_cfg);
  end

  logic [SW-1:0] q_slot;
  assign q_slot = SW'(32'(q_pid) % PROCESSES);

  // combinational search over the entry array
  logic          c_hit;
  logic [EW-1:0] c_idx;
  logic          c_inv;
  logic [EW-1:0] c_inv_idx;
  logic [EW-1:0] c_old;
  always_comb begin
    c_hit = 1'b0; c_idx = '0; c_inv = 1'b0; c_inv_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (NW'(i) < n) begin
        if (ev[i] && epid[i] == pid && epg[i] == pg) begin
          c_hit = 1'b1; c_idx = EW'(i);
        end
        if (!ev[i]) begin
          c_inv = 1'b1; c_inv_idx = EW'(i);
        end
      end
    end
  end

  // oldest-stamp tree; left side holds lower indices so ties go low
  logic               t_ok [2*TP];
  logic [STAMP_W-1:0] t_st [2*TP];
  logic [EW-1:0]      t_ix [2*TP];
  always_comb begin
    for (int j = 0; j < 2*TP; j++) begin
      t_ok[j] = 1'b0; t_st[j] = '0; t_ix[j] = '0;
    end
    for (int i = 0; i < TP; i++) begin
      if (i < ENTRIES) begin
        t_ok[TP+i] = (NW'(i) < n);
        t_st[TP+i] = est[i];
      end
      t_ix[TP+i] = EW'(i);
    end
    for (int j = TP - 1; j >= 1; j--) begin
      if (!t_ok[2*j+1] || (t_ok[2*j] && t_st[2*j] <= t_st[2*j+1])) begin
        t_ok[j] = t_ok[2*j]; t_st[j] = t_st[2*j]; t_ix[j] = t_ix[2*j];
      end else begin
        t_ok[j] = t_ok[2*j+1]; t_st[j] = t_st[2*j+1]; t_ix[j] = t_ix[2*j+1];
      end
    end
    c_old = t_ix[1];
  end

  logic [EW-1:0] fifo_v;
  assign fifo_v = ({1'b0, fifo_head} < (EW+1)'(n)) ? fifo_head : '0;

  assign q_take = (state == ST_IDLE) && q_valid;
  assign empty  = !out_full;
  assign fire   = (state == ST_DONE) && (!out_full || pop);

  always_ff @(posedge clk) begin
    if (q_take) begin
      k <= q_kind; pid <= q_pid; pg <= q_page; fr <= q_frame; slot <= q_slot;
    end
    hrd <= hmem[q_take ? q_slot : slot];
    mrd <= mmem[q_take ? q_slot : slot];
    if (state == ST_EXEC) begin
      m_hit <= c_hit;
      m_idx <= c_idx;
      v_idx <= (policy == POLICY_FIFO) ? fifo_v : (c_inv ? c_inv_idx : c_old);
    end
  end

  // counter stores: one write port each
  logic          h_we, m_we;
  logic [CNT_W-1:0] h_nv, m_nv;
  assign h_nv = (&hrd) ? hrd : hrd + 1'b1;
  assign m_nv = (&mrd) ? mrd : mrd + 1'b1;
  assign h_we = (state == ST_CLEAR) ||
                (fire && k == KIND_LOOKUP && m_hit);
  assign m_we = (state == ST_CLEAR) ||
                (fire && k == KIND_LOOKUP && !m_hit);

  always_ff @(posedge clk) begin
    if (h_we) hmem[state == ST_CLEAR ? clr_idx : slot] <= (state == ST_CLEAR) ? '0 : h_nv;
    if (m_we) mmem[state == ST_CLEAR ? clr_idx : slot] <= (state == ST_CLEAR) ? '0 : m_nv;
  end

  logic [EW:0] v_inc;
  assign v_inc = {1'b0, v_idx} + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_idx   <= '0;
      out_full  <= 1'b0;
      use_clock <= '0;
      fifo_head <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        ev[i] <= 1'b0; epid[i] <= '0; epg[i] <= '0; efr[i] <= '0; est[i] <= '0;
      end
    end else begin
      if (fire) out_full <= 1'b1;
      else if (pop && out_full) out_full <= 1'b0;
      unique case (state)
        ST_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (32'(clr_idx) == PROCESSES - 1) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (q_take) state <= ST_EXEC;
        end
        ST_EXEC: begin
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (fire) begin
            hit            <= 1'b0;
            found_frame    <= '0;
            event_count    <= '0;
            victim_valid   <= 1'b0;
            victim_process <= '0;
            victim_page    <= '0;
            unique case (k)
              KIND_LOOKUP: begin
                if (m_hit) begin
                  hit         <= 1'b1;
                  found_frame <= 16'(efr[m_idx]);
                  event_count <= h_nv;
                  est[m_idx]  <= use_clock;
                  use_clock   <= use_clock + 1'b1;
                end else begin
                  event_count <= m_nv;
                end
              end
              KIND_INSERT: begin
                if (ev[v_idx]) begin
                  victim_valid   <= 1'b1;
                  victim_process <= 8'(epid[v_idx]);
                  victim_page    <= 20'(epg[v_idx]);
                end
                ev[v_idx]   <= 1'b1;
                epid[v_idx] <= pid;
                epg[v_idx]  <= pg;
                efr[v_idx]  <= fr;
                if (policy == POLICY_LRU) begin
                  est[v_idx] <= use_clock;
                  use_clock  <= use_clock + 1'b1;
                end else begin
                  est[v_idx] <= '0;
                  fifo_head  <= ((EW+1)'(v_inc) < (EW+1)'(n)) ? EW'(v_inc) : '0;
                end
              end
              KIND_FLUSH: begin
                for (int i = 0; i < ENTRIES; i++) begin
                  ev[i] <= 1'b0; epid[i] <= '0; epg[i] <= '0;
                  efr[i] <= '0; est[i] <= '0;
                end
              end
              default: ;
            endcase
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/tlb_lru_fifo_with_process_counters_top.sv =====
// ----------------------------------------------------------------------------
// tlb_lru_fifo_with_process_counters_top
// Fully associative TLB, LRU or FIFO replacement, per-process counters.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue side: drive kind/process_id/page_number/frame_number with
//   push; a transfer happens when push is high and full is low.
//   Result side: a result is present while empty is low; pop takes it.
//   Config: cfg_valid/cfg_ready with cfg_index and cfg_data; write only
//   while idle. Index 0 is replacement policy, 1 is active entry count.
// Flow:
//   Each item passes the engine in steps (dequeue, parallel match and
//   victim search over the active entries, commit); no new item is taken
//   until the last one is committed, which waits for a free result slot.
// Reset:
//   rst clears the entries, clocks and config; the hit/miss counter memories
//   are then swept, one entry per cycle, with no item taken.
// Stall:
//   If the result is not popped, the engine holds its finished item and the
//   two-entry input queue keeps accepting until full.
// ----------------------------------------------------------------------------
module tlb_lru_fifo_with_process_counters_top #(
  parameter int ENTRIES    = tlbpc_pkg::ENTRIES_DEF,
  parameter int PROCESSES  = tlbpc_pkg::PROCESSES_DEF,
  parameter int PAGE_BITS  = tlbpc_pkg::PAGE_BITS_DEF,
  parameter int FRAME_BITS = tlbpc_pkg::FRAME_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  logic [1:0]                  kind,
  input  logic [tlbpc_pkg::PID_W-1:0] process_id,
  input  logic [PAGE_BITS-1:0]        page_number,
  input  logic [FRAME_BITS-1:0]       frame_number,
  output logic                        empty,
  input  logic                        pop,
  output logic                        hit,
  output logic [15:0]                 found_frame,
  output logic [31:0]                 event_count,
  output logic                        victim_valid,
  output logic [7:0]                  victim_process,
  output logic [19:0]                 victim_page,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [0:0]                  cfg_index,
  input  logic [31:0]                 cfg_data
);
  import tlbpc_pkg::*;

  logic       policy;
  logic [4:0] active_cfg;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      policy     <= POLICY_LRU;
      active_cfg <= 5'd16;
    end else if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_POLICY: policy     <= cfg_data[0];
        REG_ACTIVE: active_cfg <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  logic                  q_valid, q_take;
  logic [1:0]            q_kind;
  logic [PID_W-1:0]      q_pid;
  logic [PAGE_BITS-1:0]  q_page;
  logic [FRAME_BITS-1:0] q_frame;

  tlbpc_front #(.PAGE_BITS(PAGE_BITS), .FRAME_BITS(FRAME_BITS)) u_front (
    .clk, .rst, .push, .full, .kind, .process_id, .page_number, .frame_number,
    .q_valid, .q_take, .q_kind, .q_pid, .q_page, .q_frame
  );

  tlbpc_back #(
    .ENTRIES(ENTRIES), .PROCESSES(PROCESSES),
    .PAGE_BITS(PAGE_BITS), .FRAME_BITS(FRAME_BITS)
  ) u_back (
    .clk, .rst, .policy, .active_cfg,
    .q_valid, .q_take, .q_kind, .q_pid, .q_page, .q_frame,
    .empty, .pop, .hit, .found_frame, .event_count,
    .victim_valid, .victim_process, .victim_page
  );

endmodule
